// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent in the same cycle
`define AAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent a fixed number of cycles later
`define AAR_ASSERT_DLY(label, clk, rst_n, ante, n, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/aar_pkg.sv =====
// ---------------------------------------------------------------------------
// aar_pkg
// constants, tables and helpers for the axis-angle rotation matrix pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package aar_pkg;

	localparam int QW          = 32;
	localparam int LEN_SHIFT   = 28;
	localparam int SQW         = QW + LEN_SHIFT;
	localparam int SQRT_STEPS  = SQW / 2;
	localparam int LW          = SQRT_STEPS;
	localparam int DIV_STEPS   = 49;
	localparam int RECW        = DIV_STEPS;
	localparam int REM_W       = LW + 1;
	localparam int DIV_TOP     = 62;
	localparam int RLO_W       = 24;
	localparam int RHI_W       = RECW - RLO_W;
	localparam int MAGW        = 16;
	localparam int CW          = 32;
	localparam int ZW          = 35;
	localparam int ATAN_N      = 30;
	localparam int ANG_SHIFT   = 17;

	localparam logic signed [15:0] ANGLE_LIMIT = 16'sd25736;
	localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam longint OUT_ONE = 16384;

	typedef logic signed [CW-1:0] cw_t;

	localparam cw_t ATAN_Q30 [ATAN_N] = '{
		32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
		32'sd67021687, 32'sd33543516, 32'sd16775851, 32'sd8388437,
		32'sd4194283, 32'sd2097149, 32'sd1048576, 32'sd524288,
		32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768,
		32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048,
		32'sd1024, 32'sd512, 32'sd256, 32'sd128,
		32'sd64, 32'sd32, 32'sd16, 32'sd8,
		32'sd4, 32'sd2
	};

	typedef struct packed {
		logic                  zero;
		logic [2:0]            neg;
		logic [2:0][MAGW-1:0]  mag;
	} side_t;

	// round half away from zero of v / 2^s
	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
		logic [63:0] mag;
		logic [63:0] half;
		logic [63:0] r;
		mag  = v[63] ? 64'(-v) : 64'(v);
		half = (64'd1 << s) >> 1;
		r    = (mag + half) >> s;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [63:0] sat(input logic signed [63:0] v,
		input logic signed [63:0] lim);
		if (v > lim)
			return lim;
		else if (v < -lim)
			return -lim;
		else
			return v;
	endfunction

	function automatic logic signed [63:0] to_out(input logic signed [63:0] v, input int f);
		logic signed [63:0] w;
		if (f >= 14)
			w = rnd_shr(v, f - 14);
		else
			w = v <<< (14 - f);
		return sat(w, OUT_ONE);
	endfunction

	// floor(sqrt(P * 2^30)) of the cordic gain accumulation
	function automatic logic [63:0] cordic_gain(input int n);
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		p = 64'd1 << 30;
		for (int i = 0; i < n; i++)
			p = p + (p >> (2 * i));
		v   = p << 30;
		res = 64'd0;
		bt  = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (v >= res + bt) begin
				v   = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/axis_angle_rotation_matrix.sv =====
// the delay from the start beat to the done beat does not depend on the parameters
// throughput: one beat per cycle; busy stays low, the pipeline never stalls
// depth is set by the 30-stage square root and the 49-stage reciprocal divider
// the cordic runs alongside and its sine/cosine wait in a delay line
// reset clears the valid bits only; data registers are not reset
// ---------------------------------------------------------------------------
// axis_angle_rotation_matrix
// normalizes an axis, takes sine/cosine by cordic and forms the 3x3 rotation
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module axis_angle_rotation_matrix import aar_pkg::*; #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [15:0] angle,
	output logic               done,
	output logic signed [15:0] r00,
	output logic signed [15:0] r01,
	output logic signed [15:0] r02,
	output logic signed [15:0] r10,
	output logic signed [15:0] r11,
	output logic signed [15:0] r12,
	output logic signed [15:0] r20,
	output logic signed [15:0] r21,
	output logic signed [15:0] r22,
	output logic               zero_axis
);

	localparam int F       = FRAC_BITS;
	localparam int NS      = (CORDIC_STEPS > ATAN_N) ? ATAN_N : CORDIC_STEPS;
	localparam int UW      = F + 2;
	localparam int MW      = F + 3;
	localparam int PW      = F + 3;
	localparam int RW      = F + 4;
	localparam int SIDE_N  = SQRT_STEPS + DIV_STEPS + 1;
	localparam int ST_U    = 1 + SQRT_STEPS + DIV_STEPS + 2;
	localparam int ST_SC   = 3 + NS;
	localparam int DLY     = ST_U - ST_SC;
	localparam int LATENCY = 1 + SQRT_STEPS + DIV_STEPS + 5;
	localparam logic [63:0] CGAIN = cordic_gain(NS);
	localparam logic [63:0] X0    = (64'd1 << 60) / CGAIN;
	localparam longint ONE_L = longint'(1) << F;

	// ---------------- stage 1: input beat
	logic              vld_s [SIDE_N];
	side_t             side_s [SIDE_N];
	logic [QW-1:0]     q_s1;
	logic signed [15:0] ang_s1;

	logic signed [31:0] sqx, sqy, sqz;
	logic signed [15:0] ang_c;

	assign busy = 1'b0;

	always_comb begin
		sqx = axis_x * axis_x;
		sqy = axis_y * axis_y;
		sqz = axis_z * axis_z;
		if (angle > ANGLE_LIMIT)
			ang_c = ANGLE_LIMIT;
		else if (angle < -ANGLE_LIMIT)
			ang_c = -ANGLE_LIMIT;
		else
			ang_c = angle;
	end

	always_ff @(posedge clk) begin
		q_s1             <= $unsigned(sqx) + $unsigned(sqy) + $unsigned(sqz);
		ang_s1           <= ang_c;
		side_s[0].zero   <= (axis_x == 16'sd0) && (axis_y == 16'sd0) && (axis_z == 16'sd0);
		side_s[0].neg    <= {axis_z[15], axis_y[15], axis_x[15]};
		side_s[0].mag[0] <= axis_x[15] ? 16'(-axis_x) : 16'(axis_x);
		side_s[0].mag[1] <= axis_y[15] ? 16'(-axis_y) : 16'(axis_y);
		side_s[0].mag[2] <= axis_z[15] ? 16'(-axis_z) : 16'(axis_z);
		for (int k = 1; k < SIDE_N; k++)
			side_s[k] <= side_s[k-1];
	end

	// ---------------- square root, one result bit per stage
	logic [SQW-1:0] sq_rem_s  [SQRT_STEPS];
	logic [SQW-1:0] sq_root_s [SQRT_STEPS];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
		localparam logic [SQW-1:0] BT = SQW'(1) << (2 * (SQRT_STEPS - 1 - j));
		logic [SQW-1:0] n_in, r_in, trial;
		if (j == 0) begin : g_first
			assign n_in = {q_s1, LEN_SHIFT'(0)};
			assign r_in = '0;
		end else begin : g_next
			assign n_in = sq_rem_s[j-1];
			assign r_in = sq_root_s[j-1];
		end
		assign trial = r_in + BT;
		always_ff @(posedge clk) begin
			if (n_in >= trial) begin
				sq_rem_s[j]  <= n_in - trial;
				sq_root_s[j] <= (r_in >> 1) + BT;
			end else begin
				sq_rem_s[j]  <= n_in;
				sq_root_s[j] <= r_in >> 1;
			end
		end
	end

	// ---------------- reciprocal 2^62 / len, one quotient bit per stage
	logic [REM_W-1:0] dv_rem_s [DIV_STEPS];
	logic [RECW-1:0]  dv_quo_s [DIV_STEPS];
	logic [LW-1:0]    dv_len_s [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [REM_W-1:0] rem_in, sh;
		logic [RECW-1:0]  quo_in;
		logic [LW-1:0]    len_in;
		if (j == 0) begin : g_first
			assign rem_in = REM_W'(1) << (DIV_TOP - DIV_STEPS);
			assign quo_in = '0;
			assign len_in = sq_root_s[SQRT_STEPS-1][LW-1:0];
		end else begin : g_next
			assign rem_in = dv_rem_s[j-1];
			assign quo_in = dv_quo_s[j-1];
			assign len_in = dv_len_s[j-1];
		end
		assign sh = {rem_in[REM_W-2:0], 1'b0};
		always_ff @(posedge clk) begin
			dv_len_s[j] <= len_in;
			if (sh >= {1'b0, len_in}) begin
				dv_rem_s[j] <= sh - {1'b0, len_in};
				dv_quo_s[j] <= {quo_in[RECW-2:0], 1'b1};
			end else begin
				dv_rem_s[j] <= sh;
				dv_quo_s[j] <= {quo_in[RECW-2:0], 1'b0};
			end
		end
	end

	// ---------------- cordic, one rotation per stage
	cw_t         cx_s [NS+1];
	cw_t         cy_s [NS+1];
	cw_t         cz_s [NS+1];
	logic        cn_s [NS+1];
	logic signed [ZW-1:0] zf;

	assign zf = ZW'(ang_s1) <<< ANG_SHIFT;

	always_ff @(posedge clk) begin
		cx_s[0] <= CW'(X0);
		cy_s[0] <= '0;
		if (zf > HALF_PI_Q30) begin
			cz_s[0] <= CW'(zf - PI_Q30);
			cn_s[0] <= 1'b1;
		end else if (zf < -HALF_PI_Q30) begin
			cz_s[0] <= CW'(zf + PI_Q30);
			cn_s[0] <= 1'b1;
		end else begin
			cz_s[0] <= CW'(zf);
			cn_s[0] <= 1'b0;
		end
	end

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			cn_s[i+1] <= cn_s[i];
			if (!cz_s[i][CW-1]) begin
				cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] - ATAN_Q30[i];
			end else begin
				cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
				cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
				cz_s[i+1] <= cz_s[i] + ATAN_Q30[i];
			end
		end
	end

	// sine/cosine rounding, then delay line to meet the unit axis
	logic signed [UW-1:0] s_d [DLY+1];
	logic signed [UW-1:0] c_d [DLY+1];
	cw_t xf, yf;

	assign xf = cn_s[NS] ? -cx_s[NS] : cx_s[NS];
	assign yf = cn_s[NS] ? -cy_s[NS] : cy_s[NS];

	always_ff @(posedge clk) begin
		s_d[0] <= UW'(sat(rnd_shr(64'(yf), 30 - F), ONE_L));
		c_d[0] <= UW'(sat(rnd_shr(64'(xf), 30 - F), ONE_L));
		for (int k = 1; k <= DLY; k++) begin
			s_d[k] <= s_d[k-1];
			c_d[k] <= c_d[k-1];
		end
	end

	// ---------------- stage a: partial products of |a| * rec
	logic               vld_sa, zero_sa;
	logic [2:0]         neg_sa;
	logic [MAGW+RLO_W-1:0] pp_lo_sa [3];
	logic [MAGW+RHI_W-1:0] pp_hi_sa [3];
	logic [RECW-1:0]    rec;

	assign rec = dv_quo_s[DIV_STEPS-1];

	always_ff @(posedge clk) begin
		zero_sa <= side_s[SIDE_N-1].zero;
		neg_sa  <= side_s[SIDE_N-1].neg;
		for (int a = 0; a < 3; a++) begin
			pp_lo_sa[a] <= side_s[SIDE_N-1].mag[a] * rec[RLO_W-1:0];
			pp_hi_sa[a] <= side_s[SIDE_N-1].mag[a] * rec[RECW-1:RLO_W];
		end
	end

	// ---------------- stage b: unit axis
	logic                 vld_sb, zero_sb;
	logic signed [UW-1:0] u_sb [3];
	logic [65:0]          prod [3];
	logic [65:0]          rnd [3];
	logic [65:0]          umag [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod[a] = (66'(pp_hi_sa[a]) << RLO_W) + 66'(pp_lo_sa[a]);
			rnd[a]  = (prod[a] + (66'(1) << (47 - F))) >> (48 - F);
			umag[a] = (rnd[a] > 66'(ONE_L)) ? 66'(ONE_L) : rnd[a];
		end
	end

	always_ff @(posedge clk) begin
		zero_sb <= zero_sa;
		for (int a = 0; a < 3; a++)
			u_sb[a] <= neg_sa[a] ? -UW'(umag[a]) : UW'(umag[a]);
	end

	// ---------------- stage c: t = m*u, k = s*u
	logic                 vld_sc, zero_sc;
	logic signed [PW-1:0] t_sc [3];
	logic signed [UW-1:0] k_sc [3];
	logic signed [UW-1:0] u_sc [3];
	logic signed [UW-1:0] c_sc;
	logic signed [MW-1:0] m_w;
	logic signed [MW+UW-1:0] mu [3];
	logic signed [2*UW-1:0]  su [3];

	always_comb begin
		m_w = MW'(ONE_L) - MW'(c_d[DLY]);
		for (int a = 0; a < 3; a++) begin
			mu[a] = m_w * u_sb[a];
			su[a] = s_d[DLY] * u_sb[a];
		end
	end

	always_ff @(posedge clk) begin
		zero_sc <= zero_sb;
		c_sc    <= c_d[DLY];
		for (int a = 0; a < 3; a++) begin
			t_sc[a] <= PW'(rnd_shr(64'(mu[a]), F));
			k_sc[a] <= UW'(rnd_shr(64'(su[a]), F));
			u_sc[a] <= u_sb[a];
		end
	end

	// ---------------- stage d: outer products
	logic                 vld_sd, zero_sd;
	logic signed [PW-1:0] pxx_sd, pyy_sd, pzz_sd, pxy_sd, pxz_sd, pyz_sd;
	logic signed [UW-1:0] k_sd [3];
	logic signed [UW-1:0] c_sd;
	logic signed [PW+UW-1:0] txx, tyy, tzz, txy, txz, tyz;

	always_comb begin
		txx = t_sc[0] * u_sc[0];
		tyy = t_sc[1] * u_sc[1];
		tzz = t_sc[2] * u_sc[2];
		txy = t_sc[0] * u_sc[1];
		txz = t_sc[0] * u_sc[2];
		tyz = t_sc[1] * u_sc[2];
	end

	always_ff @(posedge clk) begin
		zero_sd <= zero_sc;
		c_sd    <= c_sc;
		k_sd    <= k_sc;
		pxx_sd  <= PW'(rnd_shr(64'(txx), F));
		pyy_sd  <= PW'(rnd_shr(64'(tyy), F));
		pzz_sd  <= PW'(rnd_shr(64'(tzz), F));
		pxy_sd  <= PW'(rnd_shr(64'(txy), F));
		pxz_sd  <= PW'(rnd_shr(64'(txz), F));
		pyz_sd  <= PW'(rnd_shr(64'(tyz), F));
	end

	// ---------------- stage e: entries, output beat
	logic                 vld_se, zero_se;
	logic signed [15:0]   r_se [9];
	logic signed [RW-1:0] ent [9];

	always_comb begin
		ent[0] = RW'(pxx_sd) + RW'(c_sd);
		ent[1] = RW'(pxy_sd) - RW'(k_sd[2]);
		ent[2] = RW'(pxz_sd) + RW'(k_sd[1]);
		ent[3] = RW'(pxy_sd) + RW'(k_sd[2]);
		ent[4] = RW'(pyy_sd) + RW'(c_sd);
		ent[5] = RW'(pyz_sd) - RW'(k_sd[0]);
		ent[6] = RW'(pxz_sd) - RW'(k_sd[1]);
		ent[7] = RW'(pyz_sd) + RW'(k_sd[0]);
		ent[8] = RW'(pzz_sd) + RW'(c_sd);
	end

	always_ff @(posedge clk) begin
		zero_se <= zero_sd;
		for (int e = 0; e < 9; e++)
			r_se[e] <= zero_sd ? 16'sd0 : 16'(to_out(64'(ent[e]), F));
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SIDE_N; k++)
				vld_s[k] <= 1'b0;
			vld_sa <= 1'b0;
			vld_sb <= 1'b0;
			vld_sc <= 1'b0;
			vld_sd <= 1'b0;
			vld_se <= 1'b0;
		end else begin
			vld_s[0] <= start && !busy;
			for (int k = 1; k < SIDE_N; k++)
				vld_s[k] <= vld_s[k-1];
			vld_sa <= vld_s[SIDE_N-1];
			vld_sb <= vld_sa;
			vld_sc <= vld_sb;
			vld_sd <= vld_sc;
			vld_se <= vld_sd;
		end
	end

	assign done      = vld_se;
	assign zero_axis = zero_se;
	assign r00       = r_se[0];
	assign r01       = r_se[1];
	assign r02       = r_se[2];
	assign r10       = r_se[3];
	assign r11       = r_se[4];
	assign r12       = r_se[5];
	assign r20       = r_se[6];
	assign r21       = r_se[7];
	assign r22       = r_se[8];

	`AAR_ASSERT_DLY(a_latency, clk, arst_n, start && !busy, LATENCY, done)
	`AAR_ASSERT_IMP(a_no_spurious, clk, arst_n, done, $past(start, LATENCY))
	`AAR_ASSERT_IMP(a_zero_out, clk, arst_n, done && zero_axis, r00 == 16'sd0 && r11 == 16'sd0 && r22 == 16'sd0 && r12 == 16'sd0)
	`AAR_ASSERT_IMP(a_range, clk, arst_n, done, r00 <= 16'sd16384 && r00 >= -16'sd16384 && r11 <= 16'sd16384 && r11 >= -16'sd16384 && r22 <= 16'sd16384 && r22 >= -16'sd16384)

endmodule

`default_nettype wire

// ===== dv/tb_axis_angle_rotation_matrix.sv =====
// ---------------------------------------------------------------------------
// tb_axis_angle_rotation_matrix
// drives axis/angle beats with random gaps, predicts each rotation matrix
// with an in-bench fixed-point rodrigues model and checks every done beat
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_axis_angle_rotation_matrix import aar_pkg::*;;

	localparam int STEPS = 16;
	localparam int FB = 14;
	localparam longint ANG_LIM = 25736;
	localparam longint PI_Z = 64'sd3373259426;
	localparam longint HPI_Z = 64'sd1686629713;
	localparam int TAIL = 120;
	localparam int LIMIT = 400000;

	typedef struct {
		logic signed [15:0] ax, ay, az, ang;
	} rot_req_t;

	typedef struct {
		logic signed [15:0] r [9];
		logic zero;
	} rot_mat_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic signed [15:0] axis_x = 0, axis_y = 0, axis_z = 0, angle = 0;
	logic busy, done, zero_axis;
	logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

	rot_req_t req_q [$];
	rot_mat_t mat_q [$];
	int n_req_total = 0;
	int n_sent = 0;
	int gap = 0;
	bit taken = 0;
	int errors = 0;
	int cycles = 0;

	axis_angle_rotation_matrix dut (.*);

	always #6 clk = ~clk;

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > n) bt >>= 2;
		while (bt != 0) begin
			if (n >= res + bt) begin
				n -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic longint rnd_half(longint v, int s);
		longint unsigned m;
		if (s == 0) return v;
		m = v < 0 ? -v : v;
		m = (m + (64'd1 << (s - 1))) >> s;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clip(longint v, longint lim);
		return v > lim ? lim : (v < -lim ? -lim : v);
	endfunction

	function automatic rot_mat_t rodrigues(rot_req_t q_in);
		rot_mat_t o;
		longint a [3], u [3], t [3], k [3], e [9];
		longint unsigned sq, len, rec, m, p, g;
		longint x, y, z, nx, s, c, mc, one, pxx, pyy, pzz, pxy, pxz, pyz;
		bit flip;
		one = longint'(1) << FB;
		a[0] = q_in.ax; a[1] = q_in.ay; a[2] = q_in.az;
		sq = 0;
		for (int i = 0; i < 3; i++) sq += a[i] * a[i];
		o.zero = (sq == 0);
		for (int i = 0; i < 9; i++) o.r[i] = 0;
		if (o.zero) return o;
		len = isqrt(sq << 28);
		rec = (64'd1 << 62) / len;
		for (int i = 0; i < 3; i++) begin
			m = a[i] < 0 ? -a[i] : a[i];
			m = (m * rec + (64'd1 << (47 - FB))) >> (48 - FB);
			if (m > one) m = one;
			u[i] = a[i] < 0 ? -longint'(m) : longint'(m);
		end
		// sine/cosine by rotation-mode cordic
		p = 64'd1 << 30;
		for (int i = 0; i < STEPS; i++) p += p >> (2 * i);
		g = isqrt(p << 30);
		x = longint'((64'd1 << 60) / g);
		y = 0;
		z = clip(longint'(q_in.ang), ANG_LIM) * 131072;
		flip = 0;
		if (z > HPI_Z) begin
			z -= PI_Z;
			flip = 1;
		end else if (z < -HPI_Z) begin
			z += PI_Z;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ATAN_Q30[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ATAN_Q30[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = clip(rnd_half(y, 30 - FB), one);
		c = clip(rnd_half(x, 30 - FB), one);
		mc = one - c;
		for (int i = 0; i < 3; i++) begin
			t[i] = rnd_half(mc * u[i], FB);
			k[i] = rnd_half(s * u[i], FB);
		end
		pxx = rnd_half(t[0] * u[0], FB);
		pyy = rnd_half(t[1] * u[1], FB);
		pzz = rnd_half(t[2] * u[2], FB);
		pxy = rnd_half(t[0] * u[1], FB);
		pxz = rnd_half(t[0] * u[2], FB);
		pyz = rnd_half(t[1] * u[2], FB);
		e[0] = pxx + c;    e[1] = pxy - k[2]; e[2] = pxz + k[1];
		e[3] = pxy + k[2]; e[4] = pyy + c;    e[5] = pyz - k[0];
		e[6] = pxz - k[1]; e[7] = pyz + k[0]; e[8] = pzz + c;
		for (int i = 0; i < 9; i++) o.r[i] = 16'(clip(rnd_half(e[i], FB - 14), 16384));
		return o;
	endfunction

	function automatic logic signed [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'($urandom_range(0, 8)) - 16'sd4;
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			2: return 16'($urandom_range(0, 32768)) - 16'sd16384;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(0, 7))
			0: return 16'($urandom);
			1: return 16'($urandom_range(12860, 12876))
				* ($urandom_range(0, 1) ? 16'sd1 : -16'sd1);
			2: return 16'($urandom_range(25700, 25800))
				* ($urandom_range(0, 1) ? 16'sd1 : -16'sd1);
			default: return 16'($urandom_range(0, 51472)) - 16'sd25736;
		endcase
	endfunction

	task automatic add_req(input logic signed [15:0] x, y, z, a);
		rot_req_t r;
		r.ax = x; r.ay = y; r.az = z; r.ang = a;
		req_q.push_back(r);
	endtask

	initial begin
		logic signed [15:0] dir_angles [8];
		dir_angles = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868,
			-16'sd12868, 16'sh7fff, 16'sh8000, 16'sd6434};
		add_req(0, 0, 0, 16'sd6434);
		add_req(0, 0, 0, 0);
		foreach (dir_angles[i]) add_req(16'sd16384, 0, 0, dir_angles[i]);
		add_req(0, 16'sd16384, 0, 16'sd8000);
		add_req(0, 0, 16'sd16384, -16'sd8000);
		add_req(16'sh8000, 16'sh8000, 16'sh8000, 16'sd25736);
		add_req(16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sd25736);
		add_req(16'sh7fff, 16'sh8000, 16'sd1, 16'sd12869);
		add_req(16'sd1, 0, 0, 16'sd3000);
		add_req(0, -16'sd1, 0, -16'sd3000);
		add_req(16'sd1, 16'sd1, -16'sd1, 16'sd100);
		add_req(16'sd9459, 16'sd9459, 16'sd9459, 16'sd17157);
		add_req(16'sd5, 16'sd3, 0, -16'sd1);
		for (int i = 0; i < 730; i++) begin
			if ($urandom_range(0, 9) == 0)
				add_req(0, 0, 0, rand_angle());
			else
				add_req(rand_axis(), rand_axis(), rand_axis(), rand_angle());
		end
		n_req_total = req_q.size();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!start || taken)) begin
			if (gap > 0) begin
				gap <= gap - 1;
				start <= 0;
			end else if (req_q.size() > 0 && n_sent < n_req_total - TAIL
					&& $urandom_range(0, 3) == 0) begin
				gap <= $urandom_range(0, 4);
				start <= 0;
			end else if (req_q.size() > 0) begin
				rot_req_t r;
				r = req_q.pop_front();
				axis_x <= r.ax;
				axis_y <= r.ay;
				axis_z <= r.az;
				angle <= r.ang;
				start <= 1;
				n_sent <= n_sent + 1;
			end else begin
				start <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rot_req_t r;
		rot_mat_t exp_m;
		logic signed [15:0] got [9];
		cycles <= cycles + 1;
		taken <= start && !busy;
		if (arst_n && start && !busy) begin
			r.ax = axis_x; r.ay = axis_y; r.az = axis_z; r.ang = angle;
			mat_q.push_back(rodrigues(r));
		end
		if (arst_n && done) begin
			got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
			if (mat_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected done beat");
			end else begin
				exp_m = mat_q.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== exp_m.r[i]) begin
						errors++;
						if (errors <= 10)
							$display("entry %0d: expected %0d got %0d", i, exp_m.r[i], got[i]);
					end
				if (zero_axis !== exp_m.zero) begin
					errors++;
					if (errors <= 10)
						$display("zero_axis: expected %0b got %0b", exp_m.zero, zero_axis);
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		do
			@(posedge clk);
		while (!(req_q.size() == 0 && n_sent == n_req_total && !start
			&& mat_q.size() == 0));
		repeat (200) @(posedge clk);
		if (errors == 0 && mat_q.size() == 0)
			$display("[axis_angle_rotation_matrix] OK");
		else
			$display("[axis_angle_rotation_matrix] ERROR");
		$finish;
	end

	always @(posedge clk)
		if (cycles >= LIMIT) begin
			$display("[axis_angle_rotation_matrix] ERROR");
			$finish;
		end

endmodule

`default_nettype wire
